// ----- src/periodic_timer_slot_table_assert.svh -----
// Assertion macros for the timer slot table.
`ifndef PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_SLOT_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTST_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTST_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PTST_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTST_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- src/ptst_pkg.sv -----
// Types and constants shared by the timer slot table.
`timescale 1ns / 1ps
package ptst_pkg;
  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W = $clog2(SLOT_COUNT);

  localparam logic [2:0] CMD_ALLOC_PER = 3'd0;
  localparam logic [2:0] CMD_ALLOC_ONE = 3'd1;
  localparam logic [2:0] CMD_STOP = 3'd2;
  localparam logic [2:0] CMD_FREE = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;
  localparam logic [2:0] CMD_STOP_ALL = 3'd5;
  localparam logic [2:0] CMD_CLEAR_ALL = 3'd6;

  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_RUN = 3'd1;
  localparam logic [2:0] MODE_ONESHOT = 3'd2;
  localparam logic [2:0] MODE_STOP = 3'd3;
  localparam logic [2:0] MODE_FREED = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_ARGS = 3'd1;
  localparam logic [2:0] ST_HOLDING = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic [1:0] KIND_RESP = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_TICK_DONE = 2'd2;

  typedef struct packed {
    logic [31:0] callback;
    logic [31:0] argument;
    logic [2:0]  mode;
    logic        owned;
    logic [31:0] launch_time;
    logic [31:0] next_time;
    logic [23:0] period;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);
endpackage

// ----- src/ptst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ptst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule

// ----- src/periodic_timer_slot_table.sv -----
// Timer slot table: command decode, slot scan sequencer and result register.
// A request that needs no scan goes from S_IDLE to S_RESP and registers its
// response once the output is free. An allocation, stop all or tick visits the
// slots in turn through S_RD and S_EV, a tick waiting on a stalled fire; one slot
// RAM port pair, one read and at most one write per visited slot, sets the pace.
// One request is in work at a time. Reset empties every slot at once
// through per-slot occupancy flops and zeroes the tick counter.
`timescale 1ns / 1ps
`include "periodic_timer_slot_table_assert.svh"
module periodic_timer_slot_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // callback_id, arg, interval_ms, start_delay, has_handle, handle_valid, handle_slot
  input  logic [119:0] in_tdata,
  // cmd
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, slot, slot_valid, handle_update, fire_callback, fire_arg, fire_mode
  output logic [79:0]  out_tdata,
  // kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  localparam int SW = ptst_pkg::SLOT_W;
  localparam logic [SW-1:0] LAST_IDX = SW'(ptst_pkg::SLOT_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_RESP} state_t;

  state_t state_r, state_nxt;
  logic [ptst_pkg::SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [31:0] now_r, now_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [31:0] cb_r, cb_nxt, arg_r, arg_nxt;
  logic [23:0] ivl_r, ivl_nxt, dly_r, dly_nxt;
  logic has_r, has_nxt;
  logic [1:0] rs_kind_r, rs_kind_nxt;
  logic [2:0] rs_status_r, rs_status_nxt;
  logic [3:0] rs_slot_r, rs_slot_nxt;
  logic rs_valid_r, rs_valid_nxt, rs_upd_r, rs_upd_nxt;
  logic out_tvalid_r, out_tvalid_nxt, out_tlast_r, out_tlast_nxt;
  logic [79:0] out_tdata_r, out_tdata_nxt;
  logic [1:0] out_tuser_r, out_tuser_nxt;

  logic we;
  ptst_pkg::slot_entry_t wdata, rdata;
  logic [ptst_pkg::ENTRY_W-1:0] rdata_raw;
  logic out_free, accept;
  logic [2:0] i_cmd;
  logic [31:0] i_cb, i_arg;
  logic [23:0] i_ivl, i_dly;
  logic i_has, i_hval, i_hin;
  logic [3:0] i_hs;
  logic [31:0] nn;
  logic due, fire;

  ptst_ram #(.WIDTH(ptst_pkg::ENTRY_W), .DEPTH(ptst_pkg::SLOT_COUNT)) u_ram (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (idx_r),
    .wr_data (wdata),
    .rd_en   (state_r == S_RD),
    .rd_addr (idx_r),
    .rd_data (rdata_raw)
  );
  assign rdata = rdata_raw;

  assign in_tready = (state_r == S_IDLE);
  assign accept = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;
  assign out_tlast = out_tlast_r;

  assign i_cmd = in_tuser;
  assign i_cb = in_tdata[31:0];
  assign i_arg = in_tdata[63:32];
  assign i_ivl = in_tdata[87:64];
  assign i_dly = in_tdata[111:88];
  assign i_has = in_tdata[112];
  assign i_hval = in_tdata[113];
  assign i_hs = in_tdata[117:114];
  assign i_hin = int'(i_hs) < ptst_pkg::SLOT_COUNT;

  assign nn = rdata.next_time + {8'd0, rdata.period};
  assign due = occ_r[idx_r] && (rdata.mode != ptst_pkg::MODE_FREED)
               && (rdata.launch_time <= now_r) && (rdata.next_time <= now_r);
  assign fire = !rdata.owned || (nn > now_r);

  always_comb begin
    state_nxt = state_r;
    occ_nxt = occ_r;
    now_nxt = now_r;
    idx_nxt = idx_r;
    cmd_nxt = cmd_r;
    cb_nxt = cb_r;
    arg_nxt = arg_r;
    ivl_nxt = ivl_r;
    dly_nxt = dly_r;
    has_nxt = has_r;
    rs_kind_nxt = rs_kind_r;
    rs_status_nxt = rs_status_r;
    rs_slot_nxt = rs_slot_r;
    rs_valid_nxt = rs_valid_r;
    rs_upd_nxt = rs_upd_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    out_tlast_nxt = out_tlast_r;
    we = 1'b0;
    wdata = rdata;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = i_cmd;
          cb_nxt = i_cb;
          arg_nxt = i_arg;
          ivl_nxt = i_ivl;
          dly_nxt = i_dly;
          has_nxt = i_has;
          rs_kind_nxt = ptst_pkg::KIND_RESP;
          rs_status_nxt = ptst_pkg::ST_OK;
          rs_slot_nxt = '0;
          rs_valid_nxt = 1'b0;
          rs_upd_nxt = 1'b0;
          state_nxt = S_RESP;
          priority case (i_cmd)
            ptst_pkg::CMD_ALLOC_PER, ptst_pkg::CMD_ALLOC_ONE: begin
              if (i_cb == '0 || (i_cmd == ptst_pkg::CMD_ALLOC_PER && i_ivl == '0)) begin
                rs_status_nxt = ptst_pkg::ST_BAD_ARGS;
              end else if (i_cmd == ptst_pkg::CMD_ALLOC_PER && i_has && i_hval && i_hin
                           && occ_r[SW'(i_hs)]) begin
                rs_status_nxt = ptst_pkg::ST_HOLDING;
              end else begin
                idx_nxt = SW'(1);
                state_nxt = S_RD;
              end
            end
            ptst_pkg::CMD_STOP, ptst_pkg::CMD_FREE: begin
              if (!i_has || !i_hval) begin
                rs_status_nxt = ptst_pkg::ST_BAD_ARGS;
              end else begin
                if (i_cmd == ptst_pkg::CMD_STOP) begin
                  rs_upd_nxt = 1'b1;
                end else begin
                  rs_slot_nxt = i_hs;
                  rs_valid_nxt = 1'b1;
                end
                if (i_hin && occ_r[SW'(i_hs)]) begin
                  idx_nxt = SW'(i_hs);
                  state_nxt = S_RD;
                end
              end
            end
            ptst_pkg::CMD_TICK: begin
              now_nxt = now_r + 32'd1;
              idx_nxt = SW'(1);
              state_nxt = S_RD;
            end
            ptst_pkg::CMD_STOP_ALL: begin
              idx_nxt = '0;
              state_nxt = S_RD;
            end
            ptst_pkg::CMD_CLEAR_ALL: begin
              occ_nxt = '0;
            end
            default: begin
              rs_status_nxt = ptst_pkg::ST_BAD_ARGS;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      S_EV: begin
        priority case (cmd_r)
          ptst_pkg::CMD_ALLOC_PER, ptst_pkg::CMD_ALLOC_ONE: begin
            if (occ_r[idx_r] && rdata.callback == cb_r && rdata.argument == arg_r) begin
              rs_status_nxt = ptst_pkg::ST_DUPLICATE;
              rs_slot_nxt = 4'(idx_r);
              rs_valid_nxt = (cmd_r == ptst_pkg::CMD_ALLOC_ONE);
              state_nxt = S_RESP;
            end else if (!occ_r[idx_r]) begin
              we = 1'b1;
              wdata.callback = cb_r;
              wdata.argument = arg_r;
              wdata.mode = (cmd_r == ptst_pkg::CMD_ALLOC_PER) ? ptst_pkg::MODE_START
                                                              : ptst_pkg::MODE_ONESHOT;
              wdata.owned = (cmd_r == ptst_pkg::CMD_ALLOC_PER) && has_r;
              wdata.period = (cmd_r == ptst_pkg::CMD_ALLOC_PER) ? ivl_r : 24'd0;
              wdata.launch_time = now_r + {8'd0, dly_r};
              wdata.next_time = now_r + {8'd0, dly_r};
              occ_nxt[idx_r] = 1'b1;
              rs_slot_nxt = 4'(idx_r);
              rs_valid_nxt = 1'b1;
              rs_upd_nxt = (cmd_r == ptst_pkg::CMD_ALLOC_PER) && has_r;
              state_nxt = S_RESP;
            end else if (idx_r == LAST_IDX) begin
              rs_status_nxt = ptst_pkg::ST_FULL;
              rs_upd_nxt = (cmd_r == ptst_pkg::CMD_ALLOC_PER) && has_r;
              state_nxt = S_RESP;
            end else begin
              idx_nxt = idx_r + SW'(1);
              state_nxt = S_RD;
            end
          end
          ptst_pkg::CMD_STOP, ptst_pkg::CMD_FREE: begin
            we = 1'b1;
            wdata.mode = (cmd_r == ptst_pkg::CMD_STOP) ? ptst_pkg::MODE_STOP
                                                       : ptst_pkg::MODE_FREED;
            state_nxt = S_RESP;
          end
          ptst_pkg::CMD_TICK: begin
            if (!(due && fire && !out_free)) begin
              if (due) begin
                if (fire) begin
                  out_tvalid_nxt = 1'b1;
                  out_tuser_nxt = ptst_pkg::KIND_FIRE;
                  out_tlast_nxt = 1'b0;
                  out_tdata_nxt = {4'd0, rdata.mode, rdata.argument, rdata.callback,
                                   1'b0, 1'b1, 4'(idx_r), ptst_pkg::ST_OK};
                end
                wdata.next_time = nn;
                if (rdata.mode == ptst_pkg::MODE_START) begin
                  wdata.mode = ptst_pkg::MODE_RUN;
                end
                if (rdata.mode == ptst_pkg::MODE_ONESHOT || rdata.mode == ptst_pkg::MODE_STOP) begin
                  occ_nxt[idx_r] = 1'b0;
                end else begin
                  we = 1'b1;
                end
              end
              if (idx_r == LAST_IDX) begin
                rs_kind_nxt = ptst_pkg::KIND_TICK_DONE;
                state_nxt = S_RESP;
              end else begin
                idx_nxt = idx_r + SW'(1);
                state_nxt = S_RD;
              end
            end
          end
          default: begin
            if (occ_r[idx_r]) begin
              we = 1'b1;
              wdata.next_time = now_r;
              wdata.mode = ptst_pkg::MODE_STOP;
            end
            if (idx_r == LAST_IDX) begin
              state_nxt = S_RESP;
            end else begin
              idx_nxt = idx_r + SW'(1);
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_RESP: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt = rs_kind_r;
          out_tlast_nxt = 1'b1;
          out_tdata_nxt = {4'd0, 3'd0, 32'd0, 32'd0, rs_upd_r, rs_valid_r, rs_slot_r,
                           rs_status_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r <= '0;
      now_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt;
      now_r <= now_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    cb_r <= cb_nxt;
    arg_r <= arg_nxt;
    ivl_r <= ivl_nxt;
    dly_r <= dly_nxt;
    has_r <= has_nxt;
    rs_kind_r <= rs_kind_nxt;
    rs_status_r <= rs_status_nxt;
    rs_slot_r <= rs_slot_nxt;
    rs_valid_r <= rs_valid_nxt;
    rs_upd_r <= rs_upd_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  `PTST_NEVER(a_slot0_free, clk, rst_n, occ_r[0], "slot zero became occupied")
  `PTST_ASSERT(a_rd_to_ev, clk, rst_n, state_r == S_RD |=> state_r == S_EV, "read not evaluated")
  `PTST_ASSERT(a_clear_all, clk, rst_n, accept && in_tuser == ptst_pkg::CMD_CLEAR_ALL |=> occ_r == '0, "clear all left slots")
  `PTST_NEVER(a_write_idle, clk, rst_n, we && state_r != S_EV, "slot write outside evaluation")
endmodule
